@@ hw/rtl/rtd_pkg.sv @@
// Shared types and constants for the record terminator detector.
package rtd_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SEQ1_LEN   = 3'd0,
    REG_SEQ1_BYTES = 3'd1,
    REG_SEQ2_LEN   = 3'd2,
    REG_SEQ2_BYTES = 3'd3,
    REG_SEQ3_LEN   = 3'd4,
    REG_SEQ3_BYTES = 3'd5
  } reg_idx_t;

  localparam logic [2:0] ST_LENGTH        = 3'd0;
  localparam logic [2:0] ST_SEQ1          = 3'd1;
  localparam logic [2:0] ST_SEQ2          = 3'd2;
  localparam logic [2:0] ST_SEQ3          = 3'd3;
  localparam logic [2:0] ST_TIMEOUT_DATA  = 3'd4;
  localparam logic [2:0] ST_TIMEOUT_EMPTY = 3'd5;
  localparam logic [2:0] ST_BAD_LINE      = 3'd6;

  localparam int SEQ_COUNT = 3;

  // Divide by 100: (x * 83887) >> 23 is exact for any 16-bit x.
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] bytes;
  } seq_cfg_t;

  typedef struct packed {
    logic clear;
    logic step;
  } match_ctl_t;

endpackage

@@ hw/rtl/rtd_cfg_regs.sv @@
// APB register file holding the three terminator sequences.
module rtd_cfg_regs (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output rtd_pkg::seq_cfg_t [2:0] seq_cfg
);

  logic                wr;
  rtd_pkg::reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = rtd_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_cfg <= '0;
    end else if (wr) begin
      case (idx)
        rtd_pkg::REG_SEQ1_LEN:   seq_cfg[0].len   <= pwdata[2:0];
        rtd_pkg::REG_SEQ1_BYTES: seq_cfg[0].bytes <= pwdata;
        rtd_pkg::REG_SEQ2_LEN:   seq_cfg[1].len   <= pwdata[2:0];
        rtd_pkg::REG_SEQ2_BYTES: seq_cfg[1].bytes <= pwdata;
        rtd_pkg::REG_SEQ3_LEN:   seq_cfg[2].len   <= pwdata[2:0];
        rtd_pkg::REG_SEQ3_BYTES: seq_cfg[2].bytes <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rtd_pkg::REG_SEQ1_LEN:   prdata = {29'd0, seq_cfg[0].len};
      rtd_pkg::REG_SEQ1_BYTES: prdata = seq_cfg[0].bytes;
      rtd_pkg::REG_SEQ2_LEN:   prdata = {29'd0, seq_cfg[1].len};
      rtd_pkg::REG_SEQ2_BYTES: prdata = seq_cfg[1].bytes;
      rtd_pkg::REG_SEQ3_LEN:   prdata = {29'd0, seq_cfg[2].len};
      rtd_pkg::REG_SEQ3_BYTES: prdata = seq_cfg[2].bytes;
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/rtd_matcher.sv @@
// One terminator sequence matcher with its position register.
module rtd_matcher #(
  parameter int MAX_SEQ_LEN = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  rtd_pkg::match_ctl_t ctl,
  input  rtd_pkg::seq_cfg_t   cfg,
  input  logic [7:0]          ch,
  output logic                hit
);

  localparam logic [2:0] SEQ_LIM = 3'((MAX_SEQ_LEN < 4) ? MAX_SEQ_LEN : 4);

  logic [2:0] pos;
  logic [2:0] pos_next;
  logic [2:0] len_eff;
  logic [2:0] pos_eff;
  logic [2:0] pos_inc;
  logic [7:0] expect_byte;
  logic       match;
  logic       active;

  assign len_eff     = (cfg.len > SEQ_LIM) ? SEQ_LIM : cfg.len;
  // Wrap a stale position back to the start of the sequence.
  assign pos_eff     = (pos >= len_eff) ? 3'd0 : pos;
  assign expect_byte = cfg.bytes[{pos_eff[1:0], 3'b000} +: 8];
  assign match       = (expect_byte == ch);
  assign pos_inc     = pos_eff + 3'd1;
  assign active      = ctl.step && (len_eff != 3'd0);
  assign hit         = active && match && (pos_inc >= len_eff);

  always_comb begin
    pos_next = pos;
    if (ctl.clear) begin
      pos_next = 3'd0;
    end else if (active) begin
      pos_next = match ? pos_inc : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

@@ hw/rtl/record_terminator_detector_core.sv @@
// Pipeline: an accepted transaction is captured in the input register, and its result is then
// captured in the result register, which holds while the consumer stalls; items that give no result vanish there.
// Throughput: one item per cycle, limited only by the output side's ready.
// Reset: synchronous active-high rst clears the sequence registers, matcher
// positions, the record state and both pipeline valid flags; the block is idle.
module record_terminator_detector_core #(
  parameter int LINE_COUNT  = 6,
  parameter int MAX_RECORD  = 2048,
  parameter int MAX_SEQ_LEN = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  line,
  input  logic [11:0] record_length,
  input  logic        wait_enable,
  input  logic [15:0] wait_hundredths,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        byte_valid,
  output logic [7:0]  byte_out,
  output logic [10:0] byte_index,
  output logic        record_done,
  output logic [2:0]  status,
  output logic [11:0] received_count
);

  localparam logic [7:0]  LINE_MAX = 8'(LINE_COUNT);
  localparam logic [16:0] REC_MAX  = 17'(MAX_RECORD);

  rtd_pkg::seq_cfg_t [2:0] seq_cfg;

  // Input register
  logic              s1_valid;
  rtd_pkg::cmd_t     s1_cmd;
  logic [7:0]        s1_line;
  logic [11:0]       s1_rlen;
  logic              s1_wen;
  logic [15:0]       s1_wait;
  logic [7:0]        s1_ch;
  logic              adv;
  logic              fire;

  // Record state
  logic        reading, reading_next;
  logic [11:0] byte_count, byte_count_next;
  logic [11:0] length_limit, length_limit_next;
  logic        timeout_armed, timeout_armed_next;
  logic [9:0]  seconds_left, seconds_left_next;

  // Result
  logic        res_valid;
  logic        res_byte_valid;
  logic [7:0]  res_byte;
  logic [10:0] res_index;
  logic        res_done;
  logic [2:0]  res_status;
  logic [11:0] res_count;

  rtd_pkg::match_ctl_t [2:0] mctl;
  logic [2:0]  hit;
  logic        step;
  logic        clear;
  logic [2:0]  found;
  logic [32:0] wait_prod;
  logic [9:0]  wait_secs;
  logic [11:0] rlen_clamped;
  logic [11:0] count_inc;
  logic [9:0]  secs_dec;

  rtd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seq_cfg (seq_cfg)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;
  assign fire     = s1_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd  <= rtd_pkg::cmd_t'(cmd);
      s1_line <= line;
      s1_rlen <= record_length;
      s1_wen  <= wait_enable;
      s1_wait <= wait_hundredths;
      s1_ch   <= data_byte;
    end
  end

  // Matchers in priority order: a later one does not step once an earlier one hits.
  assign clear = fire && (s1_cmd == rtd_pkg::CMD_START);
  assign step  = fire && (s1_cmd == rtd_pkg::CMD_BYTE) && reading;

  always_comb begin
    mctl[0].clear = clear;
    mctl[0].step  = step;
    mctl[1].clear = clear;
    mctl[1].step  = step && !hit[0];
    mctl[2].clear = clear;
    mctl[2].step  = step && !hit[0] && !hit[1];
  end

  for (genvar k = 0; k < rtd_pkg::SEQ_COUNT; k++) begin : g_match
    rtd_matcher #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_match (
      .clk (clk),
      .rst (rst),
      .ctl (mctl[k]),
      .cfg (seq_cfg[k]),
      .ch  (s1_ch),
      .hit (hit[k])
    );
  end

  always_comb begin
    if (hit[0]) begin
      found = rtd_pkg::ST_SEQ1;
    end else if (hit[1]) begin
      found = rtd_pkg::ST_SEQ2;
    end else if (hit[2]) begin
      found = rtd_pkg::ST_SEQ3;
    end else begin
      found = rtd_pkg::ST_LENGTH;
    end
  end

  assign wait_prod    = 33'(s1_wait) * 33'(rtd_pkg::RECIP_100);
  assign wait_secs    = wait_prod[rtd_pkg::RECIP_SHIFT +: 10];
  assign rlen_clamped = ({5'd0, s1_rlen} > REC_MAX) ? REC_MAX[11:0] : s1_rlen;
  assign count_inc    = byte_count + 12'd1;
  assign secs_dec     = (seconds_left != 10'd0) ? seconds_left - 10'd1 : seconds_left;

  always_comb begin
    reading_next       = reading;
    byte_count_next    = byte_count;
    length_limit_next  = length_limit;
    timeout_armed_next = timeout_armed;
    seconds_left_next  = seconds_left;
    res_valid          = 1'b0;
    res_byte_valid     = 1'b0;
    res_byte           = 8'd0;
    res_index          = 11'd0;
    res_done           = 1'b0;
    res_status         = rtd_pkg::ST_LENGTH;
    res_count          = 12'd0;
    if (fire) begin
      case (s1_cmd)
        rtd_pkg::CMD_START: begin
          // Drop any record in progress.
          reading_next       = 1'b0;
          byte_count_next    = 12'd0;
          timeout_armed_next = 1'b0;
          seconds_left_next  = 10'd0;
          if (s1_line == 8'd0 || s1_line > LINE_MAX) begin
            res_valid  = 1'b1;
            res_done   = 1'b1;
            res_status = rtd_pkg::ST_BAD_LINE;
          end else begin
            length_limit_next = rlen_clamped;
            if (s1_wen) begin
              seconds_left_next  = wait_secs;
              timeout_armed_next = (wait_secs != 10'd0);
            end
            if (rlen_clamped == 12'd0) begin
              timeout_armed_next = 1'b0;
              res_valid          = 1'b1;
              res_done           = 1'b1;
              res_status         = rtd_pkg::ST_LENGTH;
            end else begin
              reading_next = 1'b1;
            end
          end
        end
        rtd_pkg::CMD_BYTE: begin
          if (reading) begin
            byte_count_next = count_inc;
            res_valid       = 1'b1;
            res_byte_valid  = 1'b1;
            res_byte        = s1_ch;
            res_index       = byte_count[10:0];
            res_status      = found;
            res_count       = count_inc;
            if (found != rtd_pkg::ST_LENGTH || count_inc >= length_limit) begin
              res_done           = 1'b1;
              reading_next       = 1'b0;
              timeout_armed_next = 1'b0;
            end
          end
        end
        rtd_pkg::CMD_TICK: begin
          if (reading && timeout_armed) begin
            seconds_left_next = secs_dec;
            if (secs_dec == 10'd0) begin
              reading_next       = 1'b0;
              timeout_armed_next = 1'b0;
              res_valid          = 1'b1;
              res_done           = 1'b1;
              res_count          = byte_count;
              res_status         = (byte_count != 12'd0) ? rtd_pkg::ST_TIMEOUT_DATA
                                                         : rtd_pkg::ST_TIMEOUT_EMPTY;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading       <= 1'b0;
      byte_count    <= 12'd0;
      length_limit  <= 12'd0;
      timeout_armed <= 1'b0;
      seconds_left  <= 10'd0;
      out_valid     <= 1'b0;
    end else begin
      reading       <= reading_next;
      byte_count    <= byte_count_next;
      length_limit  <= length_limit_next;
      timeout_armed <= timeout_armed_next;
      seconds_left  <= seconds_left_next;
      if (adv) begin
        out_valid <= res_valid;
      end
    end
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (adv) begin
      byte_valid     <= res_byte_valid;
      byte_out       <= res_byte;
      byte_index     <= res_index;
      record_done    <= res_done;
      status         <= res_status;
      received_count <= res_count;
    end
  end

endmodule
